/* hw/rtl/tct_pkg.sv */
// Package for the touch contact id tracker: sizes, register indexes, reset values,
// sequencer states and the store write bundle. Depends on nothing.
`timescale 1ns / 1ps

package tct_pkg;

  localparam int MAX_CONTACTS = 5;
  localparam int IDX_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int CNT_W = $clog2(MAX_CONTACTS + 1);
  localparam int TRY_W = $clog2(MAX_CONTACTS + 2);

  localparam int COORD_W = 11;
  localparam int ID_W    = 8;
  localparam int RAD_W   = 24;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int ACC_W   = SQ_W + 1;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS_SQ = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CONTACT_ID  = 8'd1;

  localparam logic [RAD_W-1:0] MATCH_RADIUS_RESET = 24'd14400;
  localparam logic [ID_W-1:0]  MAX_ID_RESET       = 8'd250;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DY,
    ST_CMP,
    ST_RESOLVE,
    ST_DRAW,
    ST_CHK,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               swap;
  } store_wr_t;

endpackage

/* hw/rtl/tct_sq_dist.sv */
// Shared squared-distance unit: one absolute difference, one square and an accumulator.
// Used once per axis for each unclaimed stored contact. Depends on tct_pkg.
`timescale 1ns / 1ps

module tct_sq_dist import tct_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic               clear,
  input  logic [COORD_W-1:0] op_a,
  input  logic [COORD_W-1:0] op_b,
  output logic [ACC_W-1:0]   acc
);

  logic [COORD_W-1:0] diff;
  logic [SQ_W-1:0]    sq;
  logic [ACC_W-1:0]   acc_next;

  // square the absolute difference and add it to the running sum
  always_comb begin
    diff     = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);
    sq       = SQ_W'(diff) * SQ_W'(diff);
    acc_next = (clear ? '0 : acc) + ACC_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= acc_next;
    end
  end

endmodule

/* hw/rtl/tct_contact_store.sv */
// Two banks of contact entries: one holds the previous frame, the other the frame being built.
// A bank swap at frame end replaces the copy. Depends on tct_pkg.
`timescale 1ns / 1ps

module tct_contact_store import tct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  store_wr_t          wr,
  input  logic [IDX_W-1:0]   rd_idx,
  output logic [ID_W-1:0]    rd_id,
  output logic [COORD_W-1:0] rd_x,
  output logic [COORD_W-1:0] rd_y
);

  logic [ID_W-1:0]    ids [2][MAX_CONTACTS];
  logic [COORD_W-1:0] xs  [2][MAX_CONTACTS];
  logic [COORD_W-1:0] ys  [2][MAX_CONTACTS];
  logic               bank;

  // read the previous-frame bank
  assign rd_id = ids[bank][rd_idx];
  assign rd_x  = xs[bank][rd_idx];
  assign rd_y  = ys[bank][rd_idx];

  // write into the building bank
  always_ff @(posedge clk) begin
    if (wr.en) begin
      ids[~bank][wr.idx] <= wr.id;
      xs[~bank][wr.idx]  <= wr.x;
      ys[~bank][wr.idx]  <= wr.y;
    end
  end

  // swap roles at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
    end else if (wr.swap) begin
      bank <= ~bank;
    end
  end

endmodule

/* hw/rtl/touch_contact_id_tracker.sv */
// Touch contact id tracker, top level: sequencer, configuration registers and result register.
// Each point scans the stored contacts, measuring each unclaimed one and skipping claimed ones;
// if none matches, up to MAX_CONTACTS+1 fresh ids are drawn, each checked against the stored ids.
// A new point is taken only in the idle state, after the previous result is written; busy is high until then.
// An empty frame gives no result. Results are strobed for one cycle.
// Synchronous reset clears counts, claim mask, fresh counter (to one) and restores the registers.
`timescale 1ns / 1ps

module touch_contact_id_tracker import tct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   pos_x,
  input  logic [COORD_W-1:0]   pos_y,
  input  logic                 frame_last,
  input  logic                 frame_empty,
  output logic                 result_valid,
  output logic [ID_W-1:0]      contact_id,
  output logic [COORD_W-1:0]   out_x,
  output logic [COORD_W-1:0]   out_y,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_data
);

  state_t state, state_next;

  logic [RAD_W-1:0]        match_radius_sq;
  logic [ID_W-1:0]         max_contact_id;
  logic [CNT_W-1:0]        old_count;
  logic [CNT_W-1:0]        new_count;
  logic [MAX_CONTACTS-1:0] taken_mask;
  logic [ID_W-1:0]         fresh_counter;

  logic [COORD_W-1:0] cur_x, cur_y;
  logic               cur_last;
  logic [CNT_W-1:0]   j;
  logic [IDX_W-1:0]   best;
  logic               found;
  logic [RAD_W-1:0]   best_d;
  logic [ID_W-1:0]    cand;
  logic [TRY_W-1:0]   tries;
  logic [ID_W-1:0]    res_id;

  logic [IDX_W-1:0]   rd_idx;
  logic [ID_W-1:0]    rd_id;
  logic [COORD_W-1:0] rd_x, rd_y;
  logic               unit_en, unit_clear;
  logic [COORD_W-1:0] unit_a, unit_b;
  logic [ACC_W-1:0]   acc;
  store_wr_t          wr;

  logic               scan_end;
  logic               entry_taken;
  logic               chk_clash;
  logic               tries_spent;
  logic               store_room;
  logic [ID_W:0]      fresh_inc;
  logic [ID_W-1:0]    fresh_wrap;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // scan and search conditions
  always_comb begin
    scan_end    = (j == old_count);
    entry_taken = taken_mask[j[IDX_W-1:0]];
    chk_clash   = !scan_end && (rd_id == cand);
    tries_spent = (tries == TRY_W'(MAX_CONTACTS + 1));
    store_room  = (new_count < CNT_W'(MAX_CONTACTS));
    fresh_inc   = {1'b0, fresh_counter} + 9'd1;
    fresh_wrap  = (fresh_inc > {1'b0, max_contact_id} || fresh_inc > 9'd255) ?
                  ID_W'(1) : fresh_inc[ID_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && !frame_empty) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end)         state_next = ST_RESOLVE;
        else if (!entry_taken) state_next = ST_DY;
      end
      ST_DY:      state_next = ST_CMP;
      ST_CMP:     state_next = ST_SCAN;
      ST_RESOLVE: state_next = found ? ST_WRITE : ST_DRAW;
      ST_DRAW:    state_next = ST_CHK;
      ST_CHK: begin
        if (scan_end)       state_next = ST_WRITE;
        else if (chk_clash) state_next = tries_spent ? ST_WRITE : ST_DRAW;
      end
      ST_WRITE:   state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // datapath controls: read index, shared unit, store write
  always_comb begin
    rd_idx     = j[IDX_W-1:0];
    unit_en    = 1'b0;
    unit_clear = 1'b0;
    unit_a     = cur_x;
    unit_b     = rd_x;
    wr.en      = 1'b0;
    wr.idx     = new_count[IDX_W-1:0];
    wr.id      = res_id;
    wr.x       = cur_x;
    wr.y       = cur_y;
    wr.swap    = 1'b0;
    case (state)
      ST_SCAN: begin
        unit_en    = !scan_end && !entry_taken;
        unit_clear = 1'b1;
      end
      ST_DY: begin
        unit_en = 1'b1;
        unit_a  = cur_y;
        unit_b  = rd_y;
      end
      ST_RESOLVE: rd_idx = best;
      ST_WRITE: begin
        wr.en   = store_room;
        wr.swap = cur_last;
      end
      default: ;
    endcase
  end

  tct_sq_dist u_dist (
    .clk   (clk),
    .en    (unit_en),
    .clear (unit_clear),
    .op_a  (unit_a),
    .op_b  (unit_b),
    .acc   (acc)
  );

  tct_contact_store u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd_id  (rd_id),
    .rd_x   (rd_x),
    .rd_y   (rd_y)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_radius_sq <= MATCH_RADIUS_RESET;
      max_contact_id  <= MAX_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MATCH_RADIUS_SQ: match_radius_sq <= cfg_data;
        REG_MAX_CONTACT_ID:  max_contact_id  <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // frame bookkeeping and fresh counter
  always_ff @(posedge clk) begin
    if (rst) begin
      old_count     <= '0;
      new_count     <= '0;
      taken_mask    <= '0;
      fresh_counter <= ID_W'(1);
    end else begin
      case (state)
        ST_IDLE: begin
          if (start && frame_empty) begin
            old_count  <= '0;
            new_count  <= '0;
            taken_mask <= '0;
          end
        end
        ST_RESOLVE: begin
          if (found) taken_mask[best] <= 1'b1;
        end
        ST_DRAW: fresh_counter <= fresh_wrap;
        ST_WRITE: begin
          if (cur_last) begin
            old_count  <= store_room ? new_count + CNT_W'(1) : new_count;
            new_count  <= '0;
            taken_mask <= '0;
          end else if (store_room) begin
            new_count <= new_count + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // per-point working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_x    <= pos_x;
        cur_y    <= pos_y;
        cur_last <= frame_last;
        j        <= '0;
        found    <= 1'b0;
        best     <= '0;
        best_d   <= match_radius_sq;
        tries    <= '0;
      end
      ST_SCAN: begin
        if (!scan_end && entry_taken) j <= j + CNT_W'(1);
      end
      ST_CMP: begin
        if (RAD_W'(acc) < best_d) begin
          best_d <= RAD_W'(acc);
          best   <= j[IDX_W-1:0];
          found  <= 1'b1;
        end
        j <= j + CNT_W'(1);
      end
      ST_RESOLVE: res_id <= rd_id;
      ST_DRAW: begin
        cand  <= fresh_counter;
        tries <= tries + TRY_W'(1);
        j     <= '0;
      end
      ST_CHK: begin
        res_id <= cand;
        if (!scan_end && !chk_clash) j <= j + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // result strobe, held for one cycle
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= (state == ST_WRITE);
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      contact_id <= res_id;
      out_x      <= cur_x;
      out_y      <= cur_y;
      out_last   <= cur_last;
    end
  end

endmodule

/* tb/touch_contact_id_tracker_tb.sv */
// Self-checking testbench for touch_contact_id_tracker: directed frames, then random
// finger traffic under several register settings, checked against a built-in tracker model.
// Depends on tct_pkg and the touch_contact_id_tracker RTL.
`timescale 1ns / 1ps

module touch_contact_id_tracker_tb;
  import tct_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_GAP = 60;
  localparam int MAX_FINGERS = MAX_CONTACTS + 2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } contact_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [COORD_W-1:0]   pos_x;
  logic [COORD_W-1:0]   pos_y;
  logic                 frame_last;
  logic                 frame_empty;
  logic                 result_valid;
  logic [ID_W-1:0]      contact_id;
  logic [COORD_W-1:0]   out_x;
  logic [COORD_W-1:0]   out_y;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RAD_W-1:0]     cfg_data;

  touch_contact_id_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .frame_last   (frame_last),
    .frame_empty  (frame_empty),
    .result_valid (result_valid),
    .contact_id   (contact_id),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Tracker model state
  logic [RAD_W-1:0]       radius_sq;
  logic [ID_W-1:0]        id_ceiling;
  logic [ID_W-1:0]        prev_id [MAX_CONTACTS];
  logic [COORD_W-1:0]     prev_x  [MAX_CONTACTS];
  logic [COORD_W-1:0]     prev_y  [MAX_CONTACTS];
  int                     prev_n;
  logic [MAX_CONTACTS-1:0] claimed;
  logic [ID_W-1:0]        cur_id  [MAX_CONTACTS];
  logic [COORD_W-1:0]     cur_x   [MAX_CONTACTS];
  logic [COORD_W-1:0]     cur_y   [MAX_CONTACTS];
  int                     cur_n;
  logic [ID_W-1:0]        next_fresh;

  contact_t pending_contacts[$];
  int       error_count;
  int       idle_cycles;
  int       idle_pct;
  int       finger_x[$];
  int       finger_y[$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic reset_tracker_model();
    int j;
    radius_sq = MATCH_RADIUS_RESET;
    id_ceiling = MAX_ID_RESET;
    for (j = 0; j < MAX_CONTACTS; j++) begin
      prev_id[j] = '0;
      prev_x[j] = '0;
      prev_y[j] = '0;
      cur_id[j] = '0;
      cur_x[j] = '0;
      cur_y[j] = '0;
    end
    prev_n = 0;
    cur_n = 0;
    claimed = '0;
    next_fresh = 8'd1;
  endtask

  function automatic bit held_by_prev(logic [ID_W-1:0] id);
    int j;
    for (j = 0; j < prev_n; j++)
      if (prev_id[j] == id) return 1'b1;
    return 1'b0;
  endfunction

  // Draw fresh ids, skipping those the previous frame holds; give up after MAX_CONTACTS+1 tries
  function automatic logic [ID_W-1:0] draw_fresh_id();
    int tries;
    int nxt;
    logic [ID_W-1:0] id;
    id = 8'd1;
    for (tries = 0; tries <= MAX_CONTACTS; tries++) begin
      id = next_fresh;
      nxt = int'(id) + 1;
      if (nxt > int'(id_ceiling) || nxt > 255) nxt = 1;
      next_fresh = nxt[ID_W-1:0];
      if (!held_by_prev(id)) break;
    end
    return id;
  endfunction

  // Work out the id a point receives and advance the frame state
  task automatic assign_contact_id(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                   input logic last, input logic empty,
                                   output bit produced, output contact_t res);
    int best;
    int j;
    longint best_d;
    longint dx;
    longint dy;
    longint d;
    logic [ID_W-1:0] id;
    produced = 1'b0;
    res = '0;
    if (empty) begin
      prev_n = 0;
      cur_n = 0;
      claimed = '0;
    end else begin
      best = -1;
      best_d = longint'(radius_sq);
      for (j = 0; j < prev_n; j++) begin
        if (!claimed[j]) begin
          dx = longint'(x) - longint'(prev_x[j]);
          dy = longint'(y) - longint'(prev_y[j]);
          d = dx * dx + dy * dy;
          if (d < best_d) begin
            best_d = d;
            best = j;
          end
        end
      end
      if (best >= 0) begin
        claimed[best] = 1'b1;
        id = prev_id[best];
      end else begin
        id = draw_fresh_id();
      end
      // Points beyond the store are answered but not kept
      if (cur_n < MAX_CONTACTS) begin
        cur_id[cur_n] = id;
        cur_x[cur_n] = x;
        cur_y[cur_n] = y;
        cur_n++;
      end
      if (last) begin
        for (j = 0; j < MAX_CONTACTS; j++) begin
          prev_id[j] = cur_id[j];
          prev_x[j] = cur_x[j];
          prev_y[j] = cur_y[j];
        end
        prev_n = cur_n;
        cur_n = 0;
        claimed = '0;
      end
      res.id = id;
      res.x = x;
      res.y = y;
      res.last = last;
      produced = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Check each result transaction against the oldest expected contact
  always @(posedge clk) begin
    contact_t want;
    if (!rst && result_valid) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("result with nothing expected, id", int'(contact_id), 0);
      end else begin
        want = pending_contacts.pop_front();
        if (contact_id !== want.id)
          report_mismatch("contact_id", int'(contact_id), int'(want.id));
        if (out_x !== want.x) report_mismatch("out_x", int'(out_x), int'(want.x));
        if (out_y !== want.y) report_mismatch("out_y", int'(out_y), int'(want.y));
        if (out_last !== want.last)
          report_mismatch("out_last", int'(out_last), int'(want.last));
      end
    end
  end

  // Watchdog: count cycles without any transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one point; hold start until the block takes it
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic last, input logic empty);
    bit produced;
    contact_t res;
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    frame_last <= last;
    frame_empty <= empty;
    @(posedge clk);
    while (busy) @(posedge clk);
    assign_contact_id(x, y, last, empty, produced, res);
    if (produced) pending_contacts.push_back(res);
  endtask

  // Drain every expected result, then let an empty frame finish
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_contacts.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [RAD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MATCH_RADIUS_SQ) radius_sq = data;
    else if (idx == REG_MAX_CONTACT_ID) id_ceiling = data[ID_W-1:0];
  endtask

  // Junk in the upper bits must not reach the id ceiling
  task automatic write_id_ceiling(input logic [ID_W-1:0] ceiling);
    logic [RAD_W-1:0] data;
    data = RAD_W'($urandom());
    data[ID_W-1:0] = ceiling;
    write_register(REG_MAX_CONTACT_ID, data);
  endtask

  function automatic int random_coord();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return (1 << COORD_W) - 1;
    return $urandom_range((1 << COORD_W) - 1);
  endfunction

  function automatic int nudge(int c);
    int v;
    if ($urandom_range(3) == 0) return c;
    v = c + $urandom_range(120) - 60;
    if (v < 0) v = 0;
    if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
    return v;
  endfunction

  // Lift, move and add fingers for the next frame
  task automatic evolve_fingers();
    int i;
    for (i = finger_x.size() - 1; i >= 0; i--) begin
      if ($urandom_range(99) < 8) begin
        finger_x.delete(i);
        finger_y.delete(i);
      end else begin
        finger_x[i] = nudge(finger_x[i]);
        finger_y[i] = nudge(finger_y[i]);
      end
    end
    if (finger_x.size() < MAX_CONTACTS && $urandom_range(99) < 30) begin
      finger_x.push_back(random_coord());
      finger_y.push_back(random_coord());
    end
    while (finger_x.size() < MAX_FINGERS && $urandom_range(99) < 4) begin
      finger_x.push_back(random_coord());
      finger_y.push_back(random_coord());
    end
  endtask

  // Mostly well-formed frames of moving fingers, with noise, empty and broken frames mixed in
  task automatic run_traffic(input int pct, input int n_items);
    int sent;
    int roll;
    int n;
    int i;
    int k;
    int tmp;
    int order[$];
    logic broken;
    idle_pct = pct;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        send_point(COORD_W'(random_coord()), COORD_W'(random_coord()),
                   1'($urandom_range(1)), 1'b1);
      end else if (roll < 12) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
          send_point(COORD_W'(random_coord()), COORD_W'(random_coord()), i == n - 1, 1'b0);
        sent += n;
      end else begin
        evolve_fingers();
        n = finger_x.size();
        if (n == 0) begin
          send_point(COORD_W'(random_coord()), COORD_W'(random_coord()),
                     1'($urandom_range(1)), 1'b1);
        end else begin
          order.delete();
          for (i = 0; i < n; i++) order.push_back(i);
          for (i = n - 1; i > 0; i--) begin
            k = $urandom_range(i);
            tmp = order[i];
            order[i] = order[k];
            order[k] = tmp;
          end
          broken = ($urandom_range(99) < 5);
          for (i = 0; i < n; i++)
            send_point(COORD_W'(finger_x[order[i]]), COORD_W'(finger_y[order[i]]),
                       (i == n - 1) && !broken, 1'b0);
          sent += n;
        end
      end
    end
  endtask

  // Corner coordinates, then the same corners nudged and in reverse order
  task automatic test_extreme_corners();
    idle_pct = 31;
    send_point(11'd0, 11'd0, 1'b0, 1'b0);
    send_point(11'd2047, 11'd2047, 1'b0, 1'b0);
    send_point(11'd0, 11'd2047, 1'b0, 1'b0);
    send_point(11'd2047, 11'd0, 1'b1, 1'b0);
    send_point(11'd2047, 11'd1, 1'b0, 1'b0);
    send_point(11'd0, 11'd2046, 1'b0, 1'b0);
    send_point(11'd2046, 11'd2046, 1'b0, 1'b0);
    send_point(11'd1, 11'd1, 1'b1, 1'b0);
  endtask

  // Overfull frame; then nearest-first claiming and a point near an unstored contact
  task automatic test_overflow_and_claims();
    int i;
    for (i = 0; i < 7; i++)
      send_point(11'(300 + 100 * i), 11'd300, i == 6, 1'b0);
    send_point(11'd480, 11'd300, 1'b0, 1'b0);
    send_point(11'd480, 11'd300, 1'b0, 1'b0);
    send_point(11'd850, 11'd300, 1'b1, 1'b0);
  endtask

  // Empty frames drop the frame being built and the stored contacts
  task automatic test_empty_frames();
    send_point(11'd100, 11'd100, 1'b0, 1'b0);
    send_point(11'd200, 11'd200, 1'b0, 1'b0);
    send_point(11'd1234, 11'd567, 1'b1, 1'b1);
    send_point(11'd100, 11'd100, 1'b1, 1'b0);
    send_point(11'd2047, 11'd2047, 1'b0, 1'b1);
  endtask

  // Distance exactly at the limit must not match; one below must
  task automatic test_radius_boundary();
    wait_idle();
    write_register(REG_MATCH_RADIUS_SQ, 24'd100);
    send_point(11'd1000, 11'd1000, 1'b1, 1'b0);
    send_point(11'd1006, 11'd1008, 1'b1, 1'b0);
    send_point(11'd1006, 11'd1007, 1'b1, 1'b0);
    wait_idle();
    write_register(REG_MATCH_RADIUS_SQ, 24'd101);
    send_point(11'd1012, 11'd1015, 1'b1, 1'b0);
    wait_idle();
    write_register(REG_MATCH_RADIUS_SQ, MATCH_RADIUS_RESET);
  endtask

  task automatic test_default_tracking();
    run_traffic(0, 250);
  endtask

  // Lowered id ceiling below the running counter; everything in range matches
  task automatic test_wide_radius_few_ids();
    wait_idle();
    write_register(REG_MATCH_RADIUS_SQ, 24'hFFFFFF);
    write_id_ceiling(8'd16);
    run_traffic(56, 250);
  endtask

  // Only identical positions match, so fresh ids run up to the top of the range
  task automatic test_exact_radius_all_ids();
    wait_idle();
    write_register(REG_MATCH_RADIUS_SQ, 24'd1);
    write_id_ceiling(8'd255);
    run_traffic(0, 300);
  endtask

  task automatic test_random_settings();
    int round;
    logic [RAD_W-1:0] rad;
    wait_idle();
    write_register(REG_UNUSED, RAD_W'($urandom()));
    for (round = 0; round < 3; round++) begin
      wait_idle();
      case ($urandom_range(2))
        0: rad = RAD_W'($urandom_range(1, 40000));
        1: rad = RAD_W'($urandom_range(1, 24'hFFFFFF));
        default: rad = RAD_W'($urandom_range(1, 400));
      endcase
      write_register(REG_MATCH_RADIUS_SQ, rad);
      write_id_ceiling(8'($urandom_range(16, 255)));
      run_traffic(31, 85);
    end
  endtask

  // Main sequence
  initial begin
    rst = 1'b1;
    start = 1'b0;
    pos_x = '0;
    pos_y = '0;
    frame_last = 1'b0;
    frame_empty = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    idle_cycles = 0;
    idle_pct = 0;
    reset_tracker_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_extreme_corners();
    test_overflow_and_claims();
    test_empty_frames();
    test_radius_boundary();
    test_default_tracking();
    test_wide_radius_few_ids();
    test_exact_radius_all_ids();
    test_random_settings();
    wait_idle();
    if (error_count == 0 && pending_contacts.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tct_pkg.sv
hw/rtl/tct_sq_dist.sv
hw/rtl/tct_contact_store.sv
hw/rtl/touch_contact_id_tracker.sv
tb/touch_contact_id_tracker_tb.sv
